FILE: hdl/linearized_moving_average_key_map_top_assert.svh
// assertion macros for the linearized moving-average key map block
// used by linearized_moving_average_key_map_top; needs no package
`ifndef LINEARIZED_MOVING_AVERAGE_KEY_MAP_TOP_ASSERT_SVH
`define LINEARIZED_MOVING_AVERAGE_KEY_MAP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// consequent must hold in the same cycle as the antecedent
`define LMAKM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// consequent must hold in the cycle after the antecedent
`define LMAKM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LMAKM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define LMAKM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hdl/lmakm_pkg.sv
// shared constants, control-word types and microcode rom for the key map block
// no dependencies; imported by linearized_moving_average_key_map_top
package lmakm_pkg;

   localparam int SAMPLE_W           = 10;
   localparam int LEVEL_W            = 11;
   localparam int KEY_W              = 5;
   localparam int WINDOW_LEN_DEFAULT = 16;
   localparam int THRESH_RESET       = 5;

   // q16 linearisation: r * (B - A*r) - C, A taken as a magnitude
   localparam int COEF_A_MAG = 46;
   localparam int COEF_B     = 112899;
   localparam int COEF_C     = 2651718;
   localparam int FRAC_BITS  = 16;
   localparam int POLY_T_W   = 17;
   localparam int LIN_MIN    = -40;
   localparam int LIN_MAX    = 987;

   // key map 5..1000 onto 24..0
   localparam int MAP_IN_LO  = 5;
   localparam int MAP_OUT_HI = 24;
   localparam int MAP_SPAN   = 995;
   localparam int KEY_MAX    = 23;
   localparam int KD_W       = LEVEL_W + 6;
   localparam int MAG_MIN_W  = 15;
   localparam int DIVR_W     = 10;

   localparam int STEP_W = 4;

   typedef enum logic [3:0] {
      OP_ACCEPT,
      OP_POLY_T,
      OP_POLY_MUL,
      OP_POLY_FIN,
      OP_HOLD,
      OP_SUM,
      OP_AVG_LOAD,
      OP_DIV_MUL,
      OP_DIV_BACK,
      OP_DIV_FIX,
      OP_AVG_SET,
      OP_KEY_LOAD,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_NOT_PRESSED,
      COND_RSP_BUSY
   } cond_type;

   typedef enum logic {
      DIV_AVG,
      DIV_KEY
   } div_sel_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } uword_type;

   localparam logic [STEP_W-1:0] STEP_ACCEPT   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_POLY_T   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_POLY_MUL = 4'd2;
   localparam logic [STEP_W-1:0] STEP_POLY_FIN = 4'd3;
   localparam logic [STEP_W-1:0] STEP_HOLD     = 4'd4;
   localparam logic [STEP_W-1:0] STEP_SUM      = 4'd5;
   localparam logic [STEP_W-1:0] STEP_AVG_LOAD = 4'd6;
   localparam logic [STEP_W-1:0] STEP_AVG_MUL  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_AVG_BACK = 4'd8;
   localparam logic [STEP_W-1:0] STEP_AVG_FIX  = 4'd9;
   localparam logic [STEP_W-1:0] STEP_AVG_SET  = 4'd10;
   localparam logic [STEP_W-1:0] STEP_KEY_LOAD = 4'd11;
   localparam logic [STEP_W-1:0] STEP_KEY_MUL  = 4'd12;
   localparam logic [STEP_W-1:0] STEP_KEY_BACK = 4'd13;
   localparam logic [STEP_W-1:0] STEP_KEY_FIX  = 4'd14;
   localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd15;

   // microcode rom: a jump is taken when its condition holds, else fall through
   function automatic uword_type ucode(input logic [STEP_W-1:0] step);
      uword_type w;
      w = '{op: OP_ACCEPT, cond: COND_NONE, target: STEP_ACCEPT};
      case (step)
         STEP_ACCEPT:   w = '{op: OP_ACCEPT,   cond: COND_NO_REQ,      target: STEP_ACCEPT};
         STEP_POLY_T:   w = '{op: OP_POLY_T,   cond: COND_NOT_PRESSED, target: STEP_HOLD};
         STEP_POLY_MUL: w = '{op: OP_POLY_MUL, cond: COND_NONE,        target: STEP_ACCEPT};
         STEP_POLY_FIN: w = '{op: OP_POLY_FIN, cond: COND_ALWAYS,      target: STEP_SUM};
         STEP_HOLD:     w = '{op: OP_HOLD,     cond: COND_NONE,        target: STEP_ACCEPT};
         STEP_SUM:      w = '{op: OP_SUM,      cond: COND_NONE,        target: STEP_ACCEPT};
         STEP_AVG_LOAD: w = '{op: OP_AVG_LOAD, cond: COND_NONE,        target: STEP_ACCEPT};
         STEP_AVG_MUL:  w = '{op: OP_DIV_MUL,  cond: COND_NONE,        target: STEP_ACCEPT};
         STEP_AVG_BACK: w = '{op: OP_DIV_BACK, cond: COND_NONE,        target: STEP_ACCEPT};
         STEP_AVG_FIX:  w = '{op: OP_DIV_FIX,  cond: COND_NONE,        target: STEP_ACCEPT};
         STEP_AVG_SET:  w = '{op: OP_AVG_SET,  cond: COND_NONE,        target: STEP_ACCEPT};
         STEP_KEY_LOAD: w = '{op: OP_KEY_LOAD, cond: COND_NONE,        target: STEP_ACCEPT};
         STEP_KEY_MUL:  w = '{op: OP_DIV_MUL,  cond: COND_NONE,        target: STEP_ACCEPT};
         STEP_KEY_BACK: w = '{op: OP_DIV_BACK, cond: COND_NONE,        target: STEP_ACCEPT};
         STEP_KEY_FIX:  w = '{op: OP_DIV_FIX,  cond: COND_NONE,        target: STEP_ACCEPT};
         STEP_EMIT:     w = '{op: OP_EMIT,     cond: COND_RSP_BUSY,    target: STEP_EMIT};
         default:       w = '{op: OP_ACCEPT,   cond: COND_NONE,        target: STEP_ACCEPT};
      endcase
      return w;
   endfunction

endpackage

FILE: hdl/linearized_moving_average_key_map_top.sv
// linearized moving-average key map: microcoded datapath, ring in lmakm_ram
// depends on lmakm_pkg, lmakm_ram and linearized_moving_average_key_map_top_assert.svh
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  sample
//   rsp_     out        rsp_valid/rsp_stall  key_index, smoothed_level, pressed
//   csr_     in         csr_valid/csr_ready  press_threshold
//
// the microcode program steps one shared multiplier through the polynomial
// (pressed samples only) and two reciprocal divisions for each item. reset
// (synchronous) clears the ring valid bits, sum, slot and held average and
// loads the threshold with THRESH_RESET. a new transaction is taken while a
// result still waits in the output register; the program waits at its last
// step only if that register is still full and stalled.
module linearized_moving_average_key_map_top #(
   parameter int WINDOW_LEN = lmakm_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [lmakm_pkg::SAMPLE_W-1:0]       req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [lmakm_pkg::KEY_W-1:0]          rsp_key_index,
   output logic signed [lmakm_pkg::LEVEL_W-1:0] rsp_smoothed_level,
   output logic                                 rsp_pressed,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lmakm_pkg::SAMPLE_W-1:0]       csr_press_threshold
);

   import lmakm_pkg::*;

   `include "linearized_moving_average_key_map_top_assert.svh"

   localparam int SLOT_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int SUM_W   = LEVEL_W + $clog2(WINDOW_LEN);
   localparam int DIV_S   = (SUM_W > MAG_MIN_W) ? SUM_W : MAG_MIN_W;
   localparam int RECIP_W = DIV_S + 1;
   localparam int B_W     = (RECIP_W > POLY_T_W) ? RECIP_W : POLY_T_W;
   localparam int PROD_W  = DIV_S + B_W;

   // floor reciprocals; one compare-and-add afterwards makes the quotient exact
   localparam logic [RECIP_W-1:0] RECIP_AVG = RECIP_W'((2 ** DIV_S) / WINDOW_LEN);
   localparam logic [RECIP_W-1:0] RECIP_KEY = RECIP_W'((2 ** DIV_S) / MAP_SPAN);
   localparam logic [DIVR_W-1:0]  DIVR_AVG  = DIVR_W'(WINDOW_LEN);
   localparam logic [DIVR_W-1:0]  DIVR_KEY  = DIVR_W'(MAP_SPAN);

   // registers
   logic [STEP_W-1:0]         pc_ff, pc_in;
   logic [SAMPLE_W-1:0]       sample_ff, sample_in;
   logic                      pressed_ff, pressed_in;
   logic [POLY_T_W-1:0]       t_ff, t_in;
   logic signed [LEVEL_W-1:0] old_ff, old_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic signed [LEVEL_W-1:0] entry_ff, entry_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic [WINDOW_LEN-1:0]     valid_ff, valid_in;
   logic                      neg_ff, neg_in;
   logic [DIV_S-1:0]          mag_ff, mag_in;
   logic [DIV_S-1:0]          q_ff, q_in;
   div_sel_type               div_sel_ff, div_sel_in;
   logic signed [LEVEL_W-1:0] avg_ff, avg_in;
   logic [SAMPLE_W-1:0]       thr_ff, thr_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]          rsp_key_index_ff, rsp_key_index_in;
   logic signed [LEVEL_W-1:0] rsp_smoothed_level_ff, rsp_smoothed_level_in;
   logic                      rsp_pressed_ff, rsp_pressed_in;

   // datapath
   uword_type                 uw;
   logic                      jump;
   logic                      req_take;
   logic                      rsp_free;
   logic                      ring_wr;
   logic [LEVEL_W-1:0]        ring_rdata;
   logic [DIV_S-1:0]          mul_a;
   logic [B_W-1:0]            mul_b;
   logic [PROD_W-1:0]         mul_p;
   logic [RECIP_W-1:0]        recip_sel;
   logic [DIVR_W-1:0]         divr_sel;
   logic [DIV_S-1:0]          q0;
   logic [DIV_S:0]            rem;
   logic [POLY_T_W:0]         poly_t;
   logic signed [PROD_W:0]    poly_num;
   logic signed [PROD_W:0]    poly_floor;
   logic [LEVEL_W-1:0]        entry_poly;
   logic [SUM_W-1:0]          sum_abs;
   logic signed [KD_W-1:0]    key_diff;
   logic signed [KD_W-1:0]    key_d;
   logic [KD_W-1:0]           key_abs;
   logic signed [DIV_S:0]     q_sgn;
   logic signed [DIV_S+1:0]   key_val;
   logic [KEY_W-1:0]          key_clamped;

   lmakm_ram #(
      .WIDTH(LEVEL_W),
      .DEPTH(WINDOW_LEN)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (slot_ff),
      .wr_data (entry_ff),
      .rd_addr (slot_ff),
      .rd_data (ring_rdata)
   );

   assign uw        = ucode(pc_ff);
   assign req_stall = (uw.op != OP_ACCEPT);
   assign req_take  = req_valid && (uw.op == OP_ACCEPT);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign ring_wr   = (uw.op == OP_SUM);

   always_comb begin
      case (uw.cond)
         COND_ALWAYS:      jump = 1'b1;
         COND_NO_REQ:      jump = !req_valid;
         COND_NOT_PRESSED: jump = !pressed_ff;
         COND_RSP_BUSY:    jump = !rsp_free;
         default:          jump = 1'b0;
      endcase
   end

   // shared multiplier operand selection
   always_comb begin
      recip_sel = (div_sel_ff == DIV_KEY) ? RECIP_KEY : RECIP_AVG;
      divr_sel  = (div_sel_ff == DIV_KEY) ? DIVR_KEY : DIVR_AVG;
      q0        = prod_ff[DIV_S +: DIV_S];
      case (uw.op)
         OP_POLY_MUL: begin
            mul_a = DIV_S'(sample_ff);
            mul_b = B_W'(t_ff);
         end
         OP_DIV_MUL: begin
            mul_a = mag_ff;
            mul_b = B_W'(recip_sel);
         end
         OP_DIV_BACK: begin
            mul_a = q0;
            mul_b = B_W'(divr_sel);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      poly_t     = (POLY_T_W+1)'(COEF_B)
                 - (POLY_T_W+1)'(sample_ff) * (POLY_T_W+1)'(COEF_A_MAG);
      poly_num   = $signed({1'b0, prod_ff}) - (PROD_W+1)'(COEF_C);
      poly_floor = poly_num >>> FRAC_BITS;
      // floor shift plus one for a negative value with a fraction: truncation to zero
      entry_poly = poly_floor[LEVEL_W-1:0]
                 + LEVEL_W'(poly_num[PROD_W] & (|poly_num[FRAC_BITS-1:0]));
      sum_abs    = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      key_diff   = KD_W'(MAP_IN_LO) - KD_W'(avg_ff);
      key_d      = key_diff * KD_W'(MAP_OUT_HI);
      key_abs    = key_d[KD_W-1] ? KD_W'(-key_d) : KD_W'(key_d);
      rem        = {1'b0, mag_ff} - {1'b0, prod_ff[DIV_S-1:0]};
      q_sgn      = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
      key_val    = $signed({q_sgn[DIV_S], q_sgn}) + (DIV_S+2)'(MAP_OUT_HI);
      if (key_val < 0) begin
         key_clamped = '0;
      end else if (key_val > KEY_MAX) begin
         key_clamped = KEY_W'(KEY_MAX);
      end else begin
         key_clamped = key_val[KEY_W-1:0];
      end
   end

   always_comb begin
      pc_in                 = jump ? uw.target : pc_ff + STEP_W'(1);
      sample_in             = sample_ff;
      pressed_in            = pressed_ff;
      t_in                  = t_ff;
      old_in                = old_ff;
      prod_in               = prod_ff;
      entry_in              = entry_ff;
      sum_in                = sum_ff;
      slot_in               = slot_ff;
      valid_in              = valid_ff;
      neg_in                = neg_ff;
      mag_in                = mag_ff;
      q_in                  = q_ff;
      div_sel_in            = div_sel_ff;
      avg_in                = avg_ff;
      thr_in                = csr_valid ? csr_press_threshold : thr_ff;
      rsp_valid_in          = rsp_valid_ff && rsp_stall;
      rsp_key_index_in      = rsp_key_index_ff;
      rsp_smoothed_level_in = rsp_smoothed_level_ff;
      rsp_pressed_in        = rsp_pressed_ff;
      case (uw.op)
         OP_ACCEPT: begin
            if (req_take) begin
               sample_in  = req_sample;
               pressed_in = (req_sample >= thr_ff);
            end
         end
         OP_POLY_T: begin
            t_in   = poly_t[POLY_T_W-1:0];
            // a slot never written since reset reads as zero
            old_in = valid_ff[slot_ff] ? $signed(ring_rdata) : '0;
         end
         OP_POLY_MUL: begin
            prod_in = mul_p;
         end
         OP_POLY_FIN: begin
            entry_in = $signed(entry_poly);
         end
         OP_HOLD: begin
            entry_in = avg_ff;
         end
         OP_SUM: begin
            sum_in            = sum_ff - SUM_W'(old_ff) + SUM_W'(entry_ff);
            valid_in[slot_ff] = 1'b1;
            slot_in           = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + SLOT_W'(1);
         end
         OP_AVG_LOAD: begin
            neg_in     = sum_ff[SUM_W-1];
            mag_in     = DIV_S'(sum_abs);
            div_sel_in = DIV_AVG;
         end
         OP_DIV_MUL: begin
            prod_in = mul_p;
         end
         OP_DIV_BACK: begin
            q_in    = q0;
            prod_in = mul_p;
         end
         OP_DIV_FIX: begin
            q_in = q_ff + DIV_S'(rem >= (DIV_S+1)'(divr_sel));
         end
         OP_AVG_SET: begin
            avg_in = q_sgn[LEVEL_W-1:0];
         end
         OP_KEY_LOAD: begin
            neg_in     = key_d[KD_W-1];
            mag_in     = DIV_S'(key_abs);
            div_sel_in = DIV_KEY;
         end
         OP_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in          = 1'b1;
               rsp_key_index_in      = key_clamped;
               rsp_smoothed_level_in = avg_ff;
               rsp_pressed_in        = pressed_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sample_ff             <= sample_in;
      pressed_ff            <= pressed_in;
      t_ff                  <= t_in;
      old_ff                <= old_in;
      prod_ff               <= prod_in;
      entry_ff              <= entry_in;
      neg_ff                <= neg_in;
      mag_ff                <= mag_in;
      q_ff                  <= q_in;
      div_sel_ff            <= div_sel_in;
      rsp_key_index_ff      <= rsp_key_index_in;
      rsp_smoothed_level_ff <= rsp_smoothed_level_in;
      rsp_pressed_ff        <= rsp_pressed_in;
      if (reset) begin
         pc_ff        <= STEP_ACCEPT;
         sum_ff       <= '0;
         slot_ff      <= '0;
         valid_ff     <= '0;
         avg_ff       <= '0;
         thr_ff       <= SAMPLE_W'(THRESH_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         sum_ff       <= sum_in;
         slot_ff      <= slot_in;
         valid_ff     <= valid_in;
         avg_ff       <= avg_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_key_index      = rsp_key_index_ff;
   assign rsp_smoothed_level = rsp_smoothed_level_ff;
   assign rsp_pressed        = rsp_pressed_ff;

   `LMAKM_ASSERT_IMPL(a_lin_range, clock, reset, (uw.op == OP_SUM) && pressed_ff,
      (entry_ff >= LIN_MIN) && (entry_ff <= LIN_MAX), "linearised entry out of range")
   `LMAKM_ASSERT_IMPL(a_div_rem, clock, reset, uw.op == OP_DIV_FIX,
      rem < (DIV_S+1)'({divr_sel, 1'b0}), "reciprocal quotient off by more than one")
   `LMAKM_ASSERT_NEXT(a_emit, clock, reset, (uw.op == OP_EMIT) && rsp_free,
      rsp_valid_ff && (rsp_key_index_ff <= KEY_MAX), "result not presented or key unclamped")
   `LMAKM_ASSERT_IMPL(a_slot, clock, reset, 1'b1,
      slot_ff <= SLOT_W'(WINDOW_LEN - 1), "ring slot beyond window")

endmodule

FILE: hdl/lmakm_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; holds the history ring of the key map block
module lmakm_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sim/testbench.sv
// self-checking bench for linearized_moving_average_key_map_top
// depends on lmakm_pkg and the rtl of the block; a directed table then random phases
`timescale 1ns / 100ps

module testbench;
   import lmakm_pkg::*;

   localparam int WINDOW = WINDOW_LEN_DEFAULT;

   typedef struct packed {
      logic [KEY_W-1:0]          key_index;
      logic signed [LEVEL_W-1:0] level;
      logic                      pressed;
   } key_reading_type;

   typedef enum logic {
      ROW_SAMPLE,
      ROW_THRESHOLD
   } row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [SAMPLE_W-1:0] value;
      logic                typed_in;
      key_reading_type     want;
   } stimulus_row_type;

   typedef enum int {
      REGION_ANY,
      REGION_LOW,
      REGION_HIGH,
      REGION_EDGE,
      REGION_RAIL
   } region_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [SAMPLE_W-1:0]        req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [KEY_W-1:0]           rsp_key_index;
   logic signed [LEVEL_W-1:0]  rsp_smoothed_level;
   logic                       rsp_pressed;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [SAMPLE_W-1:0]        csr_press_threshold = SAMPLE_W'(THRESH_RESET);

   // predictor state, set as the block is at reset
   int                  level_ring [WINDOW] = '{default: 0};
   int                  level_sum = 0;
   int                  ring_slot = 0;
   int                  held_level = 0;
   logic [SAMPLE_W-1:0] press_threshold = SAMPLE_W'(THRESH_RESET);

   key_reading_type expected_keys [$];
   int              mismatch_count = 0;
   bit              no_gaps = 1'b0;

   localparam int DIRECTED_ROWS = 23;
   stimulus_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_SAMPLE,    10'd0,    1'b1, '{5'd23, 11'sd0, 1'b0}},
      '{ROW_SAMPLE,    10'd4,    1'b1, '{5'd23, 11'sd0, 1'b0}},
      '{ROW_SAMPLE,    10'd5,    1'b0, '0},
      '{ROW_SAMPLE,    10'h2AA,  1'b0, '0},
      '{ROW_SAMPLE,    10'h155,  1'b0, '0},
      '{ROW_SAMPLE,    10'd1023, 1'b0, '0},
      '{ROW_SAMPLE,    10'd1023, 1'b0, '0},
      '{ROW_SAMPLE,    10'd1023, 1'b0, '0},
      '{ROW_SAMPLE,    10'd1023, 1'b0, '0},
      '{ROW_SAMPLE,    10'd1023, 1'b0, '0},
      '{ROW_SAMPLE,    10'd1023, 1'b0, '0},
      '{ROW_SAMPLE,    10'd1023, 1'b0, '0},
      '{ROW_SAMPLE,    10'd1023, 1'b0, '0},
      '{ROW_SAMPLE,    10'd1023, 1'b0, '0},
      '{ROW_SAMPLE,    10'd1023, 1'b0, '0},
      '{ROW_SAMPLE,    10'd1023, 1'b0, '0},
      '{ROW_SAMPLE,    10'd1023, 1'b0, '0},
      '{ROW_THRESHOLD, 10'd1023, 1'b0, '0},
      '{ROW_SAMPLE,    10'd1022, 1'b0, '0},
      '{ROW_SAMPLE,    10'd1023, 1'b0, '0},
      '{ROW_THRESHOLD, 10'd0,    1'b0, '0},
      '{ROW_SAMPLE,    10'd0,    1'b0, '0},
      '{ROW_SAMPLE,    10'd0,    1'b0, '0}
   };

   linearized_moving_average_key_map_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_key_index       (rsp_key_index),
      .rsp_smoothed_level  (rsp_smoothed_level),
      .rsp_pressed         (rsp_pressed),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_press_threshold (csr_press_threshold)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // linearise or hold, update the window and map the new average onto a key
   function automatic key_reading_type predict_key_reading(input logic [SAMPLE_W-1:0] sample);
      longint          poly;
      int              entry;
      int              avg;
      int              key;
      key_reading_type reading;
      reading.pressed = (sample >= press_threshold);
      if (reading.pressed) begin
         poly = -COEF_A_MAG * longint'(sample) * longint'(sample)
                + COEF_B * longint'(sample) - COEF_C;
         entry = int'(poly / 65536);
      end else begin
         entry = held_level;
      end
      level_sum = level_sum - level_ring[ring_slot] + entry;
      level_ring[ring_slot] = entry;
      ring_slot = (ring_slot + 1) % WINDOW;
      avg = level_sum / WINDOW;
      held_level = avg;
      key = MAP_OUT_HI + ((avg - MAP_IN_LO) * -MAP_OUT_HI) / MAP_SPAN;
      if (key < 0) key = 0;
      if (key > KEY_MAX) key = KEY_MAX;
      reading.key_index = key[KEY_W-1:0];
      reading.level = avg[LEVEL_W-1:0];
      return reading;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample(input region_type region,
                                                       input int threshold);
      int lo;
      int hi;
      lo = (threshold < 2) ? 0 : threshold - 2;
      hi = (threshold > 1021) ? 1023 : threshold + 2;
      case (region)
         REGION_LOW:  return SAMPLE_W'($urandom_range(20));
         REGION_HIGH: return SAMPLE_W'($urandom_range(1023, 990));
         REGION_EDGE: return SAMPLE_W'($urandom_range(hi, lo));
         REGION_RAIL: return $urandom_range(1) ? 10'd1023 : 10'd0;
         default:     return SAMPLE_W'($urandom);
      endcase
   endfunction

   // called and left at a falling edge; valid stays high for a following transaction
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic typed_in,
                              input key_reading_type want);
      key_reading_type reading;
      while (!no_gaps && $urandom_range(99) < 37) begin
         req_valid  <= 1'b0;
         req_sample <= SAMPLE_W'($urandom);
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= sample;
      do @(posedge clock); while (req_stall);
      reading = predict_key_reading(sample);
      expected_keys.push_back(typed_in ? want : reading);
      @(negedge clock);
   endtask

   // only once the block has drained every result
   task automatic write_threshold(input logic [SAMPLE_W-1:0] threshold);
      req_valid <= 1'b0;
      while (expected_keys.size() != 0) @(negedge clock);
      csr_valid           <= 1'b1;
      csr_press_threshold <= threshold;
      do @(posedge clock); while (!csr_ready);
      press_threshold = threshold;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_stall <= !no_gaps && ($urandom_range(99) < 37);
   end

   always @(posedge clock) begin
      key_reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_keys.size() == 0) begin
            $display("%0t: unexpected transaction key_index %0d smoothed_level %0d pressed %0d",
                     $time, rsp_key_index, rsp_smoothed_level, rsp_pressed);
            mismatch_count++;
         end else begin
            want = expected_keys.pop_front();
            if (rsp_key_index !== want.key_index) begin
               $display("%0t: key_index expected %0d actual %0d",
                        $time, want.key_index, rsp_key_index);
               mismatch_count++;
            end
            if (rsp_smoothed_level !== want.level) begin
               $display("%0t: smoothed_level expected %0d actual %0d",
                        $time, want.level, rsp_smoothed_level);
               mismatch_count++;
            end
            if (rsp_pressed !== want.pressed) begin
               $display("%0t: pressed expected %0d actual %0d",
                        $time, want.pressed, rsp_pressed);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #1000000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      region_type          region;
      logic [SAMPLE_W-1:0] threshold;
      int                  row;
      int                  phase;
      int                  n;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (directed_rows[row].kind == ROW_THRESHOLD)
            write_threshold(directed_rows[row].value);
         else
            send_sample(directed_rows[row].value, directed_rows[row].typed_in,
                        directed_rows[row].want);
      end

      region = REGION_ANY;
      for (phase = 0; phase < 10; phase++) begin
         case (phase)
            0:       threshold = 10'd0;
            1:       threshold = 10'd1023;
            2:       threshold = SAMPLE_W'(THRESH_RESET);
            default: threshold = $urandom_range(1) ? SAMPLE_W'($urandom_range(1023))
                                                   : SAMPLE_W'($urandom_range(60));
         endcase
         write_threshold(threshold);
         no_gaps = (phase == 4);
         for (n = 0; n < 55; n++) begin
            // runs of about a window length let the average settle at the extremes
            if (n % 16 == 0) region = region_type'($urandom_range(4));
            send_sample(pick_sample(region, int'(threshold)), 1'b0, '0);
         end
         no_gaps = 1'b0;
      end

      req_valid <= 1'b0;
      while (expected_keys.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
